/* rtl/core/base58_encoder_defines.svh */
// Assertion macros for the base58 encoder core.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef BASE58_ENCODER_DEFINES_SVH
`define BASE58_ENCODER_DEFINES_SVH

// same-cycle implication
`define B58_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define B58_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/b58_pkg.sv */
// Shared types, constants and the alphabet lookup for the base58 encoder.
// No dependencies.
`default_nettype none

package b58_pkg;

    localparam int MAX_BYTES   = 4096;
    localparam int DIGIT_SLOTS = 5654;

    localparam int ADDR_W  = $clog2(DIGIT_SLOTS);
    localparam int CNT_W   = 13;
    localparam int CAP_W   = 16;
    localparam int DIGIT_W = 6;
    localparam int CARRY_W = 9;
    localparam int CHAR_W  = 7;
    localparam int BYTE_W  = 8;

    localparam logic [CHAR_W-1:0] CHAR_ONE = 7'h31;

    localparam logic [58*8-1:0] ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_FINISH = 2'd1,
        OP_PULL   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_TOO_LARGE = 2'd1,
        STS_TOO_SMALL = 2'd2,
        STS_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_PULL_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [DIGIT_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } t_ram_req;

    function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] dc;
        logic [7:0]         ch;
        dc = (d > 6'd57) ? 6'd57 : d;
        ch = ALPHABET[(6'd57 - dc) * 8 +: 8];
        return ch[CHAR_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/b58_digit_ram.sv */
// Digit store: one write port, one registered read port.
// Depends on b58_pkg.
`default_nettype none

module b58_digit_ram (
    input  wire                           i_clk,
    input  b58_pkg::t_ram_req             i_req,
    output logic [b58_pkg::DIGIT_W-1:0]   o_rdata
);
    import b58_pkg::*;

    logic [DIGIT_W-1:0] r_mem [DIGIT_SLOTS];
    logic [DIGIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/b58_mac_unit.sv */
// One base-58 digit step: t = 256*digit + carry, digit' = t mod 58, carry' = t / 58.
// Depends on b58_pkg.
`default_nettype none

module b58_mac_unit (
    input  wire  [b58_pkg::DIGIT_W-1:0] i_digit,
    input  wire  [b58_pkg::CARRY_W-1:0] i_carry,
    output logic [b58_pkg::DIGIT_W-1:0] o_digit,
    output logic [b58_pkg::CARRY_W-1:0] o_carry
);
    import b58_pkg::*;

    // 256*d = 58*(4*d) + 24*d, so only u = 24*d + carry needs dividing
    logic [10:0] u;
    logic [20:0] prod;
    logic [4:0]  q;
    logic [10:0] q58;
    logic [10:0] rem;

    always_comb begin
        u    = {1'b0, i_digit, 4'b0} + {2'b0, i_digit, 3'b0} + {2'b0, i_carry};
        prod = u * 21'd565;
        q    = prod[19:15];
        q58  = {1'b0, q, 5'b0} + {2'b0, q, 4'b0} + {3'b0, q, 3'b0} + {5'b0, q, 1'b0};
        rem  = u - q58;
        o_digit = rem[DIGIT_W-1:0];
        o_carry = {1'b0, i_digit, 2'b0} + {4'b0, q};
    end

endmodule

`default_nettype wire

/* rtl/core/base58_encoder.sv */
// Top level of the base58 encoder: sequencer, message state and output register.
// Depends on b58_pkg, b58_digit_ram, b58_mac_unit and base58_encoder_defines.svh.
//
//  channel   dir  handshake                      payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tuser=op, tdata=byte,capacity
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tuser=status, tlast, tdata=char,len
//
// Push into the zero prefix or past the size limit stays in idle. Push that folds:
//   walks the digits touched, one digit per cycle through the shared digit unit
//   (fill count plus carry growth).
// Finish or a '1' pull goes to the emit step; a digit pull waits on the store read.
// Reset clears control state only; the store is tracked by a fill count.
// A finished result waits in the output register; finish or pull holds in its
//   emit step while that register is still full.
`default_nettype none
`include "base58_encoder_defines.svh"

module base58_encoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [23:0] i_s_axis_tdata,   // data_byte[7:0], out_capacity[23:8]
    input  wire  [1:0]  i_s_axis_tuser,   // operation[1:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // encoded_char[6:0], encoded_length[19:7], zero
    output logic [1:0]  o_m_axis_tuser,   // status[1:0]
    output logic        o_m_axis_tlast    // last_char
);
    import b58_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [CNT_W-1:0]   r_bc, n_bc;
    logic [CNT_W-1:0]   r_zp, n_zp;
    logic               r_allz, n_allz;
    logic               r_toolarge, n_toolarge;
    logic               r_fin, n_fin;
    logic               r_readable, n_readable;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]   r_j, n_j;
    logic [CARRY_W-1:0] r_carry, n_carry;

    logic [CHAR_W-1:0]  r_res_char, n_res_char;
    logic               r_res_last, n_res_last;
    t_status            r_res_sts, n_res_sts;
    logic [CNT_W-1:0]   r_res_len, n_res_len;

    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic               r_out_last, n_out_last;
    t_status            r_out_sts, n_out_sts;
    logic [CNT_W-1:0]   r_out_len, n_out_len;

    t_ram_req           ram_req;
    logic [DIGIT_W-1:0] ram_rdata;
    logic [DIGIT_W-1:0] mac_din;
    logic [DIGIT_W-1:0] mac_dout;
    logic [CARRY_W-1:0] mac_cout;

    logic               s_acc;
    t_op                op;
    logic [BYTE_W-1:0]  in_byte;
    logic [CAP_W-1:0]   in_cap;
    logic [CNT_W-1:0]   c_bc, c_zp, len, jn, offs, rd_idx;
    logic               c_allz;

    b58_digit_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    b58_mac_unit u_mac (
        .i_digit (mac_din),
        .i_carry (r_carry),
        .o_digit (mac_dout),
        .o_carry (mac_cout)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc   = i_s_axis_tvalid & o_s_axis_tready;
    assign op      = t_op'(i_s_axis_tuser);
    assign in_byte = i_s_axis_tdata[7:0];
    assign in_cap  = i_s_axis_tdata[23:8];
    assign mac_din = (r_j < r_used) ? ram_rdata : '0;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out_len, r_out_char};
    assign o_m_axis_tuser  = r_out_sts;
    assign o_m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_bc        <= '0;
            r_zp        <= '0;
            r_allz      <= 1'b1;
            r_toolarge  <= 1'b0;
            r_fin       <= 1'b0;
            r_readable  <= 1'b0;
            r_total     <= '0;
            r_rp        <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_bc        <= n_bc;
            r_zp        <= n_zp;
            r_allz      <= n_allz;
            r_toolarge  <= n_toolarge;
            r_fin       <= n_fin;
            r_readable  <= n_readable;
            r_total     <= n_total;
            r_rp        <= n_rp;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry    <= n_carry;
        r_res_char <= n_res_char;
        r_res_last <= n_res_last;
        r_res_sts  <= n_res_sts;
        r_res_len  <= n_res_len;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_sts  <= n_out_sts;
        r_out_len  <= n_out_len;
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_bc        = r_bc;
        n_zp        = r_zp;
        n_allz      = r_allz;
        n_toolarge  = r_toolarge;
        n_fin       = r_fin;
        n_readable  = r_readable;
        n_total     = r_total;
        n_rp        = r_rp;
        n_j         = r_j;
        n_carry     = r_carry;
        n_res_char  = r_res_char;
        n_res_last  = r_res_last;
        n_res_sts   = r_res_sts;
        n_res_len   = r_res_len;
        n_out_valid = r_out_valid & ~i_m_axis_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_sts   = r_out_sts;
        n_out_len   = r_out_len;
        ram_req     = '0;

        c_bc   = r_fin ? '0 : r_bc;
        c_zp   = r_fin ? '0 : r_zp;
        c_allz = r_fin | r_allz;
        len    = r_zp + r_used;
        jn     = r_j + 1'b1;
        offs   = r_rp - r_zp;
        rd_idx = r_used - 1'b1 - offs;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (op)
                        OP_PUSH: begin
                            if (r_fin) begin
                                // new message: drop the old one
                                n_used     = '0;
                                n_bc       = '0;
                                n_zp       = '0;
                                n_allz     = 1'b1;
                                n_toolarge = 1'b0;
                                n_fin      = 1'b0;
                                n_readable = 1'b0;
                                n_total    = '0;
                                n_rp       = '0;
                            end
                            if (c_bc >= CNT_W'(MAX_BYTES)) begin
                                n_toolarge = 1'b1;
                            end else begin
                                n_bc = c_bc + 1'b1;
                                if (c_allz && in_byte == '0) begin
                                    n_zp = c_zp + 1'b1;
                                end else begin
                                    n_allz        = 1'b0;
                                    n_carry       = {1'b0, in_byte};
                                    n_j           = '0;
                                    ram_req.re    = 1'b1;
                                    ram_req.raddr = '0;
                                    n_state       = ST_FOLD;
                                end
                            end
                        end
                        OP_FINISH: begin
                            n_fin      = 1'b1;
                            n_rp       = '0;
                            n_readable = 1'b0;
                            n_total    = '0;
                            n_res_char = '0;
                            n_res_last = 1'b0;
                            n_res_len  = '0;
                            if (r_toolarge) begin
                                n_res_sts = STS_TOO_LARGE;
                            end else if (in_cap <= {{(CAP_W-CNT_W){1'b0}}, len}) begin
                                n_res_sts = STS_TOO_SMALL;
                            end else begin
                                n_res_sts  = STS_OK;
                                n_res_len  = len;
                                n_readable = 1'b1;
                                n_total    = len;
                            end
                            n_state = ST_EMIT;
                        end
                        OP_PULL: begin
                            n_res_char = '0;
                            n_res_len  = '0;
                            n_res_last = 1'b0;
                            if (!r_readable || r_rp >= r_total) begin
                                n_res_sts = STS_EMPTY;
                                n_state   = ST_EMIT;
                            end else begin
                                n_res_sts  = STS_OK;
                                n_rp       = r_rp + 1'b1;
                                n_res_last = (n_rp == r_total);
                                if (r_rp < r_zp) begin
                                    n_res_char = CHAR_ONE;
                                    n_state    = ST_EMIT;
                                end else begin
                                    ram_req.re    = 1'b1;
                                    ram_req.raddr = rd_idx[ADDR_W-1:0];
                                    n_state       = ST_PULL_WAIT;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FOLD: begin
                // slot j counts up from the least significant digit
                ram_req.we    = 1'b1;
                ram_req.waddr = r_j[ADDR_W-1:0];
                ram_req.wdata = mac_dout;
                n_carry       = mac_cout;
                if (r_j >= r_used) begin
                    n_used = jn;
                end
                if ((jn < r_used || mac_cout != '0) && jn < CNT_W'(DIGIT_SLOTS)) begin
                    n_j           = jn;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = jn[ADDR_W-1:0];
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PULL_WAIT: begin
                n_res_char = b58_char(ram_rdata);
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_res_char;
                    n_out_last  = r_res_last;
                    n_out_sts   = r_res_sts;
                    n_out_len   = r_res_len;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `B58_ASSERT_NOW(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CNT_W'(DIGIT_SLOTS), "fill")
    `B58_ASSERT_NOW(a_fold_in_fill, i_clk, i_rst_n, r_state == ST_FOLD, r_j <= r_used, "fold")
    `B58_ASSERT_NEXT(a_fold_step, i_clk, i_rst_n, r_state == ST_FOLD, (r_state != ST_FOLD) || (r_j == $past(r_j) + 1'b1), "skip")
    `B58_ASSERT_NOW(a_last_ok, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tuser == STS_OK, "last")

endmodule

`default_nettype wire

/* tb/base58_encoder_checker.sv */
// Checker for the base58 encoder: watches both stream channels, predicts each result word
// from the accepted input words and compares field by field. Depends on b58_pkg.
`timescale 1ns / 1ps

module base58_encoder_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    input  wire        i_s_tready,
    input  wire [23:0] i_s_tdata,   // data_byte[7:0], out_capacity[23:8]
    input  wire [1:0]  i_s_tuser,   // operation[1:0]
    input  wire        i_m_tvalid,
    input  wire        i_m_tready,
    input  wire [23:0] i_m_tdata,   // encoded_char[6:0], encoded_length[19:7], zero
    input  wire [1:0]  i_m_tuser,   // status[1:0]
    input  wire        i_m_tlast,   // last_char
    output int         o_fails,
    output int         o_pending
);
    import b58_pkg::*;

    typedef struct packed {
        logic [6:0]  ch;
        logic        last;
        t_status     st;
        logic [12:0] len;
    } t_b58_word;

    string b58_digits = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    logic [DIGIT_W-1:0] digit_mem [DIGIT_SLOTS];
    int unsigned msg_bytes;
    int unsigned zero_lead;
    int unsigned top_digit;
    int unsigned read_ptr;
    int unsigned text_len;
    bit          leading_only;
    bit          oversize;
    bit          msg_closed;
    bit          text_ready;

    t_b58_word   b58_expected_q[$];
    int          mismatch_count = 0;

    function automatic void clear_msg();
        for (int k = 0; k < DIGIT_SLOTS; k++) digit_mem[k] = '0;
        msg_bytes    = 0;
        zero_lead    = 0;
        top_digit    = 0;
        read_ptr     = 0;
        text_len     = 0;
        leading_only = 1'b1;
        oversize     = 1'b0;
        msg_closed   = 1'b0;
        text_ready   = 1'b0;
    endfunction

    // store = store * 256 + b, least significant slot last
    function automatic void fold_byte(input logic [7:0] b);
        int unsigned carry;
        carry = b;
        for (int k = DIGIT_SLOTS - 1; k >= 0; k--) begin
            carry = carry + 256 * digit_mem[k];
            digit_mem[k] = DIGIT_W'(carry % 58);
            carry = carry / 58;
        end
    endfunction

    function automatic void predict_b58(input t_op op, input logic [7:0] b,
                                        input logic [15:0] cap);
        t_b58_word   w;
        int unsigned i;
        int unsigned n;
        int unsigned d;
        w = '0;
        case (op)
            OP_PUSH: begin
                if (msg_closed) clear_msg();
                if (msg_bytes >= MAX_BYTES) begin
                    oversize = 1'b1;
                end else begin
                    msg_bytes++;
                    if (leading_only && b == 8'h00) begin
                        zero_lead++;
                    end else begin
                        leading_only = 1'b0;
                        fold_byte(b);
                    end
                end
            end
            OP_FINISH: begin
                msg_closed = 1'b1;
                read_ptr   = 0;
                text_ready = 1'b0;
                text_len   = 0;
                if (oversize) begin
                    w.st = STS_TOO_LARGE;
                end else begin
                    i = 0;
                    while (i < DIGIT_SLOTS && digit_mem[i] == '0) i++;
                    top_digit = i;
                    n = zero_lead + DIGIT_SLOTS - i;
                    if (cap < n + 1) begin
                        w.st = STS_TOO_SMALL;
                    end else begin
                        w.st       = STS_OK;
                        w.len      = 13'(n);
                        text_ready = 1'b1;
                        text_len   = n;
                    end
                end
                b58_expected_q.push_back(w);
            end
            OP_PULL: begin
                if (!text_ready || read_ptr >= text_len) begin
                    w.st = STS_EMPTY;
                end else begin
                    w.st = STS_OK;
                    if (read_ptr < zero_lead) begin
                        w.ch = CHAR_ONE;
                    end else begin
                        i = top_digit + read_ptr - zero_lead;
                        d = (i < DIGIT_SLOTS) ? digit_mem[i] : 0;
                        if (d > 57) d = 57;
                        w.ch = 7'(b58_digits[d]);
                    end
                    read_ptr++;
                    w.last = (read_ptr == text_len);
                end
                b58_expected_q.push_back(w);
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_b58_word got;
        t_b58_word want;
        bit        had_want;
        if (!i_rst_n) begin
            clear_msg();
            b58_expected_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                predict_b58(t_op'(i_s_tuser), i_s_tdata[7:0], i_s_tdata[23:8]);
            if (i_m_tvalid && i_m_tready) begin
                got.ch   = i_m_tdata[6:0];
                got.len  = i_m_tdata[19:7];
                got.st   = t_status'(i_m_tuser);
                got.last = i_m_tlast;
                had_want = (b58_expected_q.size() != 0);
                want     = had_want ? b58_expected_q.pop_front() : '0;
                if (!had_want || got.ch !== want.ch || got.last !== want.last ||
                    got.st !== want.st || got.len !== want.len) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        if (!had_want)
                            $display("%0t: unexpected word ch=%h last=%b st=%0d len=%0d",
                                     $realtime, got.ch, got.last, got.st, got.len);
                        else
                            $display("%0t: exp ch=%h l=%b st=%0d len=%0d got ch=%h l=%b st=%0d len=%0d",
                                     $realtime, want.ch, want.last, want.st, want.len,
                                     got.ch, got.last, got.st, got.len);
                    end
                end
            end
        end
        o_fails   = mismatch_count;
        o_pending = b58_expected_q.size();
    end

endmodule

/* tb/base58_encoder_tb.sv */
// Testbench top for the base58 encoder: clock, reset, input words, output stalls and verdict.
// Depends on b58_pkg, base58_encoder and base58_encoder_checker.
`timescale 1ns / 1ps

module base58_encoder_tb;
    import b58_pkg::*;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 6000;
    localparam int RANDOM_WORDS   = 65;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;
    wire  [1:0]  m_tuser;
    wire         m_tlast;
    int          fails;
    int          pending;

    bit          src_quiet = 1'b0;
    bit          sink_quiet = 1'b0;
    bit          hold_req = 1'b0;
    int          words_sent = 0;

    base58_encoder DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    base58_encoder_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tlast  (m_tlast),
        .o_fails    (fails),
        .o_pending  (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic int idle_len(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    task automatic send_word(input t_op op, input logic [7:0] b, input logic [15:0] cap);
        int gap;
        gap = idle_len(src_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {cap, b};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op != OP_NONE) words_sent++;
    endtask

    task automatic pull_chars(input int n);
        repeat (n) send_word(OP_PULL, 8'($urandom), 16'($urandom));
    endtask

    // output side: random stalls, one long hold on request
    initial begin : sink
        int n;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0) sink_quiet = !sink_quiet;
            if (hold_req) begin
                hold_req = 1'b0;
                n = HOLD_CYCLES;
            end else begin
                n = idle_len(sink_quiet);
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** base58_encoder: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int  nbytes;
        int  zeros;
        int  pulls;
        int  r;
        int  random_start;
        bit  pressure_done;
        logic [7:0]  b;
        logic [15:0] cap;

        pressure_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing readable yet, ignored op, empty message
        send_word(OP_PULL, 8'hFF, 16'hFFFF);
        send_word(OP_NONE, 8'hFF, 16'hFFFF);
        send_word(OP_FINISH, 8'h00, 16'h0000);
        send_word(OP_FINISH, 8'h00, 16'h0001);
        send_word(OP_PULL, 8'h00, 16'h0000);

        // leading zeros and capacity boundary, repeated finish
        send_word(OP_PUSH, 8'h00, 16'hFFFF);
        send_word(OP_PUSH, 8'h00, 16'h0000);
        send_word(OP_PUSH, 8'h01, 16'h0000);
        send_word(OP_FINISH, 8'h00, 16'd3);
        send_word(OP_PULL, 8'h00, 16'h0000);
        send_word(OP_FINISH, 8'hFF, 16'd4);
        pull_chars(4);

        send_word(OP_PUSH, 8'hFF, 16'hFFFF);
        send_word(OP_PUSH, 8'hFF, 16'h0000);
        send_word(OP_FINISH, 8'h00, 16'hFFFF);
        pull_chars(2);
        send_word(OP_FINISH, 8'h00, 16'hFFFF);
        pull_chars(1);
        send_word(OP_PUSH, 8'h80, 16'h5A5A);
        send_word(OP_PUSH, 8'h00, 16'hA5A5);
        send_word(OP_FINISH, 8'h00, 16'h8000);
        pull_chars(4);

        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            src_quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0)
                send_word(t_op'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
            nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
            zeros  = $urandom_range(0, 3);
            for (int i = 0; i < nbytes; i++) begin
                r = $urandom_range(0, 9);
                if (i < zeros || r == 0) b = 8'h00;
                else if (r == 1)         b = 8'hFF;
                else                     b = 8'($urandom);
                send_word(OP_PUSH, b, 16'($urandom));
            end
            r = $urandom_range(0, 3);
            case (r)
                0:       cap = 16'hFFFF;
                1:       cap = 16'($urandom);
                default: cap = 16'($urandom_range(0, nbytes * 2 + 2));
            endcase
            pulls = $urandom_range(0, nbytes * 3 / 2 + 4);
            if (!pressure_done && words_sent - random_start >= 40) begin
                pressure_done = 1'b1;
                hold_req      = 1'b1;
                cap           = 16'hFFFF;
                pulls         = 20;
            end
            send_word(OP_FINISH, 8'($urandom), cap);
            if ($urandom_range(0, 5) == 0)
                send_word(OP_FINISH, 8'($urandom), 16'($urandom_range(0, 64)));
            pull_chars(pulls);
        end
        send_word(OP_FINISH, 8'h00, 16'hFFFF);
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("** base58_encoder: PASSED **");
        else
            $display("** base58_encoder: FAILED **");
        $finish;
    end

endmodule
